[hw/rtl/ps2mt_pkg.sv]
// Shared types and constants for the PS/2 mouse packet tracker.
`default_nettype none

package ps2mt_pkg;

  // Input item as it sits in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_aux;
  } ps2mt_item_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam int unsigned SCREEN_W = 13;
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd400;

  // Header byte layout
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned X_SIGN_BIT = 4;
  localparam int unsigned Y_SIGN_BIT = 5;
  localparam int unsigned BUTTON_W   = 3;

  // Packet phase codes
  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_X   = 2'd1;
  localparam logic [1:0] PH_Y   = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/ps2_mouse_packet_tracker_top.sv]
// The result of a packet's third byte reaches m_axis via the input and output registers.
// Throughput: one byte per cycle unless stalled; the input register feeds the tracker.
// The input stalls only while a finished result waits in the output register.
// Reset (rst_ni low, async): phase idle, cursor at 0,0, screen 640 by 400, stages empty.
// Config writes are taken in any cycle; cfg_ready_o is always high.
`default_nettype none

module ps2_mouse_packet_tracker_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [7:0]                           s_axis_tdata,  // data_byte
  input  wire                                  s_axis_tuser,  // from_aux
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // pos_x, pos_y, button_bits, then zero fill
  output logic [((2*COORD_BITS+ps2mt_pkg::BUTTON_W+7)/8)*8-1:0] m_axis_tdata,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [ps2mt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [ps2mt_pkg::SCREEN_W-1:0]       cfg_data_i
);
  import ps2mt_pkg::*;

  localparam int unsigned RES_W  = 2*COORD_BITS + BUTTON_W;
  localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

  ps2mt_item_t in_item, cur_item;
  logic        cur_valid, drain, res_valid, out_ready, out_load;
  logic [RES_W-1:0] res_data, out_data;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.from_aux  = s_axis_tuser;

  // The held byte moves on unless it finishes a packet and the output is full and stalled
  assign drain    = cur_valid && (!res_valid || out_ready);
  assign out_load = res_valid && out_ready;
  assign cfg_ready_o = 1'b1;

  ps2mt_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .drain_i (drain),
    .valid_o (cur_valid),
    .item_o  (cur_item)
  );

  ps2mt_tracker #(.COORD_BITS(COORD_BITS)) u_trk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (cur_valid),
    .item_i       (cur_item),
    .step_i       (drain),
    .res_valid_o  (res_valid),
    .res_data_o   (res_data)
  );

  ps2mt_out_stage #(.DATA_W(RES_W)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (res_data),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_data)
  );

  assign m_axis_tdata = TDATA_W'(out_data);

endmodule

`default_nettype wire

[hw/rtl/ps2mt_in_stage.sv]
// Input register stage: holds one accepted byte until the tracker consumes it.
`default_nettype none

module ps2mt_in_stage (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  output logic                  ready_o,
  input  ps2mt_pkg::ps2mt_item_t item_i,
  input  wire                   drain_i,
  output logic                  valid_o,
  output ps2mt_pkg::ps2mt_item_t item_o
);
  import ps2mt_pkg::*;

  logic        valid_q, valid_d;
  ps2mt_item_t item_q;
  logic        load;

  assign ready_o = !valid_q || drain_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[hw/rtl/ps2mt_tracker.sv]
// Packet assembly, cursor update and clamping, plus the screen size registers.
`default_nettype none

module ps2mt_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [ps2mt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [ps2mt_pkg::SCREEN_W-1:0]    cfg_data_i,
  input  wire                              item_valid_i,
  input  ps2mt_pkg::ps2mt_item_t           item_i,
  input  wire                              step_i,
  output logic                             res_valid_o,
  output logic [2*COORD_BITS+ps2mt_pkg::BUTTON_W-1:0] res_data_o
);
  import ps2mt_pkg::*;

  localparam int unsigned EW = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
  localparam logic [EW-1:0] TOP = EW'(1) << COORD_BITS;

  logic [1:0]            phase_q, phase_d;
  logic [7:0]            header_q, xbyte_q;
  logic [COORD_BITS-1:0] cursor_x_q, cursor_y_q, cursor_x_d, cursor_y_d;
  logic [SCREEN_W-1:0]   width_q, height_q;

  logic [EW-1:0] max_x, max_y, nx, ny, dx, dy;
  logic          is_y_byte;

  function automatic logic [EW-1:0] max_coord(logic [SCREEN_W-1:0] lim);
    logic [EW-1:0] ext;
    ext = EW'(lim);
    if (lim == '0) begin
      max_coord = '0;
    end else if (ext > TOP) begin
      max_coord = TOP - EW'(1);
    end else begin
      max_coord = ext - EW'(1);
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(logic [EW-1:0] v, logic [EW-1:0] mx);
    logic [EW-1:0] r;
    if (v[EW-1]) begin
      r = '0;
    end else if (v > mx) begin
      r = mx;
    end else begin
      r = v;
    end
    clamp = r[COORD_BITS-1:0];
  endfunction

  assign max_x = max_coord(width_q);
  assign max_y = max_coord(height_q);

  // 9-bit motion: sign comes from the header, low eight bits from the data byte
  assign dx = {{(EW-8){header_q[X_SIGN_BIT]}}, xbyte_q};
  assign dy = {{(EW-8){header_q[Y_SIGN_BIT]}}, item_i.data_byte};
  assign nx = EW'(cursor_x_q) + dx;
  assign ny = EW'(cursor_y_q) - dy;

  assign is_y_byte  = item_i.from_aux && (phase_q == PH_Y);
  assign cursor_x_d = clamp(nx, max_x);
  assign cursor_y_d = clamp(ny, max_y);

  assign res_valid_o = item_valid_i && is_y_byte;
  assign res_data_o  = {header_q[BUTTON_W-1:0], cursor_y_d, cursor_x_d};

  always_comb begin
    case (phase_q)
      PH_X:    phase_d = PH_Y;
      PH_Y:    phase_d = PH_HDR;
      default: phase_d = item_i.data_byte[SYNC_BIT] ? PH_X : PH_HDR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR;
      header_q   <= '0;
      xbyte_q    <= '0;
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      width_q    <= SCREEN_WIDTH_RST;
      height_q   <= SCREEN_HEIGHT_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
          REG_SCREEN_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (step_i && item_i.from_aux) begin
        phase_q <= phase_d;
        case (phase_q)
          PH_X: xbyte_q <= item_i.data_byte;
          PH_Y: begin
            cursor_x_q <= cursor_x_d;
            cursor_y_q <= cursor_y_d;
          end
          default: header_q <= item_i.data_byte;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ps2mt_out_stage.sv]
// Output register: holds one result item until the sink takes it.
`default_nettype none

module ps2mt_out_stage #(
  parameter int unsigned DATA_W = 27
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               load_i,
  input  wire  [DATA_W-1:0] data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  wire               ready_i,
  output logic [DATA_W-1:0] data_o
);

  logic              valid_q, valid_d;
  logic [DATA_W-1:0] data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[hw/rtl/ps2mt_checker.sv]
// Port-level checks for the PS/2 mouse packet tracker, bound to the top level.
`default_nettype none

module ps2mt_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input wire clk_i,
  input wire rst_ni,
  input wire s_axis_tvalid,
  input wire s_axis_tready,
  input wire s_axis_tuser,
  input wire m_axis_tvalid,
  input wire m_axis_tready,
  input wire [((2*COORD_BITS+ps2mt_pkg::BUTTON_W+7)/8)*8-1:0] m_axis_tdata
);

  logic s_acc_aux;
  assign s_acc_aux = s_axis_tvalid && s_axis_tready && s_axis_tuser;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // Input backpressure only comes from a result blocked at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked result");

  // A fresh result follows a mouse byte accepted earlier at the input
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_acc_aux, 2))
    else $error("result item without a mouse byte behind it");

endmodule

bind ps2_mouse_packet_tracker_top ps2mt_checker #(.COORD_BITS(COORD_BITS)) u_ps2mt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
